@@ design/id_escape_encoder_core_macros.svh @@
// Assertion macros shared by the id escape encoder RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ID_ESCAPE_ENCODER_CORE_MACROS_SVH
`define ID_ESCAPE_ENCODER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IDESC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IDESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/idesc_pkg.sv @@
// Types, constants and helper functions for the id escape encoder.
// No dependencies.
package idesc_pkg;

  localparam int unsigned MaxUnits = 4;
  localparam int unsigned HeldDepth = 3;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;

  // position of a character inside an escaped unit
  localparam logic [1:0] EscPosPct = 2'd0;
  localparam logic [1:0] EscPosHi  = 2'd1;
  localparam logic [1:0] EscPosLo  = 2'd2;

  typedef enum logic [1:0] {
    CLASS_ASCII = 2'd0,
    CLASS_BYTE  = 2'd1,
    CLASS_UTF8  = 2'd2
  } charset_e;

  // one output unit: a byte sent as is, or as %XX
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
  } unit_t;

  typedef struct packed {
    unit_t [MaxUnits-1:0] units;
    logic  [2:0]          count;
  } unit_list_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = 8'h37 + {4'h0, nib};
    end
    return res;
  endfunction

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0) begin
      n = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      n = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  function automatic logic is_overlong(input logic [2:0] n, input logic [7:0] b0,
                                       input logic [7:0] b1);
    logic res;
    res = 1'b0;
    if (n == 3'd2 && (b0 & 8'h1E) == 8'h00) res = 1'b1;
    if (n == 3'd3 && b0 == 8'hE0 && (b1 & 8'h20) == 8'h00) res = 1'b1;
    if (n == 3'd4 && b0 == 8'hF0 && (b1 & 8'h30) == 8'h00) res = 1'b1;
    return res;
  endfunction

endpackage

@@ design/idesc_decode.sv @@
// Byte classifier and pending utf8 sequence holder for the id escape encoder.
// Depends on idesc_pkg and id_escape_encoder_core_macros.svh.
`include "id_escape_encoder_core_macros.svh"

module idesc_decode
  import idesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  charset_e   class_i,
  output unit_list_t list_o
);

  logic [7:0] held_q [HeldDepth];
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] seq_q, seq_d;

  logic       wr_en;
  logic [1:0] wr_idx;
  logic [1:0] pre;
  logic       pre_esc, new_unit, new_esc;
  logic       holding, cont;
  logic [2:0] n_lead;
  logic       f_esc, f_hold;
  logic [7:0] second;

  always_comb begin
    cont    = (byte_i[7:6] == 2'b10);
    holding = (cnt_q != 2'd0) && (seq_q >= 3'd2) && (seq_q <= 3'd4);
    n_lead  = lead_length(byte_i);
    second  = (cnt_q >= 2'd2) ? held_q[1] : byte_i;

    f_hold = byte_i[7] && (class_i == CLASS_UTF8) && (n_lead >= 3'd2) && !last_i;
    f_esc  = (byte_i == CharPct) || (byte_i == CharNul) ||
             (byte_i == CharSpace && last_i) ||
             (byte_i[7] && (class_i != CLASS_BYTE));

    pre      = 2'd0;
    pre_esc  = 1'b1;
    new_unit = 1'b1;
    new_esc  = f_esc;
    cnt_d    = 2'd0;
    seq_d    = 3'd0;
    wr_en    = 1'b0;
    wr_idx   = 2'd0;

    if (holding && cont) begin
      pre = cnt_q;
      if ({1'b0, cnt_q} + 3'd1 >= seq_q) begin
        pre_esc = is_overlong(seq_q, held_q[0], second);
        new_esc = pre_esc;
      end else if (last_i) begin
        new_esc = 1'b1;
      end else begin
        pre      = 2'd0;
        new_unit = 1'b0;
        wr_en    = 1'b1;
        wr_idx   = cnt_q;
        cnt_d    = cnt_q + 2'd1;
        seq_d    = seq_q;
      end
    end else begin
      pre = holding ? cnt_q : 2'd0;
      if (f_hold) begin
        new_unit = 1'b0;
        wr_en    = 1'b1;
        wr_idx   = 2'd0;
        cnt_d    = 2'd1;
        seq_d    = n_lead;
      end
    end

    for (int i = 0; i < HeldDepth; i++) begin
      if (pre > 2'(i)) begin
        list_o.units[i].data = held_q[i];
        list_o.units[i].esc  = pre_esc;
      end else begin
        list_o.units[i].data = byte_i;
        list_o.units[i].esc  = new_esc;
      end
    end
    list_o.units[MaxUnits-1].data = byte_i;
    list_o.units[MaxUnits-1].esc  = new_esc;
    list_o.count = {1'b0, pre} + {2'b00, new_unit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      seq_q <= 3'd0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      held_q[wr_idx] <= byte_i;
    end
  end

  `IDESC_ASSERT_IMP(a_held_below_len, cnt_q != 2'd0, ({1'b0, cnt_q} < seq_q) && (seq_q <= 3'd4), "held count not below sequence length")
  `IDESC_ASSERT_IMP(a_len_clear, cnt_q == 2'd0, seq_q == 3'd0, "sequence length set with nothing held")
  `IDESC_ASSERT_IMP(a_hold_silent, accept_i && wr_en && !holding, list_o.count == 3'd0, "new lead gave output")

endmodule

@@ design/id_escape_encoder_core.sv @@
// Top level of the id escape encoder: config register, decode and output serialiser.
// Depends on idesc_pkg, idesc_decode and id_escape_encoder_core_macros.svh.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata in_byte, tlast in_last
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata out_char, tlast out_last
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_wdata_i charset_class
//
// An input byte is decoded in the cycle it is taken; its output units sit in one
// result register and leave one character per cycle while the output is ready
// (1 to 12 characters). A byte that gives one character is taken every such cycle;
// otherwise with the last character of the previous one. Bytes held back give none.
// Reset clears the held sequence and result valid flag, and sets the class to ascii.
// Output stalls stall the input only through the result register.
`include "id_escape_encoder_core_macros.svh"

module id_escape_encoder_core
  import idesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_char
  output logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_wdata_i
);

  charset_e   class_q;
  unit_list_t list_new;
  unit_list_t list_q, list_d;
  logic       valid_q, valid_d;
  logic [1:0] u_q, u_d;
  logic [1:0] s_q, s_d;
  logic       last_q, last_d;
  unit_t      cur;
  logic       unit_final, item_final, s_fire, m_fire, load;
  logic [7:0] out_char;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= CLASS_ASCII;
    end else if (cfg_valid_i) begin
      class_q <= charset_e'(cfg_wdata_i);
    end
  end

  idesc_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_fire),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .class_i  (class_q),
    .list_o   (list_new)
  );

  always_comb begin
    cur        = list_q.units[u_q];
    unit_final = !cur.esc || (s_q == EscPosLo);
    item_final = unit_final && ({1'b0, u_q} == list_q.count - 3'd1);
    case (s_q)
      EscPosPct: out_char = cur.esc ? CharPct : cur.data;
      EscPosHi:  out_char = hex_char(cur.data[7:4]);
      EscPosLo:  out_char = hex_char(cur.data[3:0]);
      default:   out_char = cur.data;
    endcase
  end

  assign s_axis_tready = !valid_q || (item_final && m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = valid_q && m_axis_tready;
  assign load          = s_fire && (list_new.count != 3'd0);

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = out_char;
  assign m_axis_tlast  = last_q && item_final;

  always_comb begin
    valid_d = valid_q;
    u_d     = u_q;
    s_d     = s_q;
    list_d  = list_q;
    last_d  = last_q;
    if (m_fire) begin
      if (unit_final) begin
        s_d = 2'd0;
        u_d = u_q + 2'd1;
        if (item_final) valid_d = 1'b0;
      end else begin
        s_d = s_q + 2'd1;
      end
    end
    if (load) begin
      valid_d = 1'b1;
      u_d     = 2'd0;
      s_d     = 2'd0;
      list_d  = list_new;
      last_d  = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      u_q     <= 2'd0;
      s_q     <= 2'd0;
    end else begin
      valid_q <= valid_d;
      u_q     <= u_d;
      s_q     <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
    last_q <= last_d;
  end

  `IDESC_ASSERT_IMP(a_unit_in_range, valid_q, {1'b0, u_q} < list_q.count, "unit index beyond result count")
  `IDESC_ASSERT_IMP(a_digit_only_esc, valid_q && (s_q != 2'd0), cur.esc, "hex digit position on a plain unit")
  `IDESC_ASSERT_NEXT(a_result_kept, valid_q && !(item_final && m_axis_tready), valid_q, "result dropped before final character")

endmodule
